FILE: hw/rtl/bounded_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded priority queue
// Shared concurrent-assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication
`define BPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bounded_priority_queue: assertion failed");

// Next-cycle implication
`define BPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bounded_priority_queue: assertion failed");

`endif

FILE: hw/rtl/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Opcodes, fixed field widths and the per-cell control word shared by the
// priority queue cells and the top level.
// ----------------------------------------------------------------------------
package bpq_pkg;

	// Opcode field
	localparam int unsigned OP_W = 2;
	localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	// Width of the reported count field
	localparam int unsigned COUNT_W = 5;

	// Control word broadcast to every cell
	typedef struct packed {
		logic add_en;   // insert a new entry, cells at or after the slot shift down
		logic ext_en;   // remove the head, all cells shift up
	} cell_ctl_t;

endpackage

FILE: hw/rtl/bpq_cell.sv
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted queue. Holds a tag and a priority, compares the
// incoming priority against its own and takes data from the new word, its
// upper neighbor (insert) or its lower neighbor (extract).
// ----------------------------------------------------------------------------
module bpq_cell #(
	parameter int unsigned TAG_BITS      = 16,
	parameter int unsigned PRIORITY_BITS = 8
) (
	input  logic                     clk,
	input  bpq_pkg::cell_ctl_t       ctl,
	input  logic                     occupied,
	input  logic [TAG_BITS-1:0]      new_tag,
	input  logic [PRIORITY_BITS-1:0] new_pri,
	input  logic                     prev_ins,
	input  logic [TAG_BITS-1:0]      prev_tag,
	input  logic [PRIORITY_BITS-1:0] prev_pri,
	input  logic [TAG_BITS-1:0]      next_tag,
	input  logic [PRIORITY_BITS-1:0] next_pri,
	output logic                     ins,
	output logic [TAG_BITS-1:0]      tag,
	output logic [PRIORITY_BITS-1:0] pri
);

	logic [TAG_BITS-1:0]      tag_q;
	logic [PRIORITY_BITS-1:0] pri_q;

	// At or past the insertion slot: empty, or strictly lower priority
	assign ins = !occupied || (new_pri > pri_q);

	// Slot contents
	always_ff @(posedge clk) begin
		if (ctl.add_en && ins) begin
			if (prev_ins) begin
				tag_q <= prev_tag;
				pri_q <= prev_pri;
			end else begin
				tag_q <= new_tag;
				pri_q <= new_pri;
			end
		end else if (ctl.ext_en) begin
			tag_q <= next_tag;
			pri_q <= next_pri;
		end
	end

	assign tag = tag_q;
	assign pri = pri_q;

endmodule

FILE: hw/rtl/bounded_priority_queue.sv
// ----------------------------------------------------------------------------
// bounded_priority_queue
// Sorted priority queue built as a row of cells, highest priority at cell 0,
// equal priorities kept in arrival order. Add, extract head and clear, one
// result word per operation with count, empty and full.
// ----------------------------------------------------------------------------
//
//   channel  signals                                   dir   words
//   in       in_valid in_stall opcode entry_tag       in    one per operation
//            priority_req
//   rsp      rsp_valid rsp_stall out_tag out_valid     out   one per input word
//            accepted count is_empty is_full
//
// All cells compare against the new priority in parallel and shift together,
// so one word is taken per cycle while in_stall is low.
// The result is registered; its word appears the cycle after acceptance.
// in_stall is high only while a result waits and rsp_stall is high.
// Reset empties the queue (count to zero); cell contents are not cleared.
// ----------------------------------------------------------------------------
`include "bounded_priority_queue_macros.svh"

module bounded_priority_queue #(
	parameter int unsigned DEPTH         = 16,
	parameter int unsigned TAG_BITS      = 16,
	parameter int unsigned PRIORITY_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bpq_pkg::OP_W-1:0]     opcode,
	input  logic [TAG_BITS-1:0]          entry_tag,
	input  logic [PRIORITY_BITS-1:0]     priority_req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [TAG_BITS-1:0]          out_tag,
	output logic                         out_valid,
	output logic                         accepted,
	output logic [bpq_pkg::COUNT_W-1:0]  count,
	output logic                         is_empty,
	output logic                         is_full
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic                     in_acc;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_nxt;
	logic                     full;
	logic                     empty;
	logic                     do_add;
	logic                     do_ext;
	bpq_pkg::cell_ctl_t       ctl;

	logic [TAG_BITS-1:0]      tag_w [DEPTH];
	logic [PRIORITY_BITS-1:0] pri_w [DEPTH];
	logic                     ins_w [DEPTH];

	logic                     rsp_valid_q;
	logic [TAG_BITS-1:0]      out_tag_q;
	logic                     out_valid_q;
	logic                     accepted_q;
	logic [bpq_pkg::COUNT_W-1:0] count_q;
	logic                     is_empty_q;
	logic                     is_full_q;

	// Handshake: take a word unless a result is waiting and stalled
	assign in_stall = rsp_valid_q && rsp_stall;
	assign in_acc   = in_valid && !in_stall;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

	// Decode and next count
	always_comb begin
		do_add  = 1'b0;
		do_ext  = 1'b0;
		cnt_nxt = cnt_q;
		case (opcode)
			bpq_pkg::OP_ADD: begin
				do_add = !full;
				if (!full) begin
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			bpq_pkg::OP_EXTRACT: begin
				do_ext = !empty;
				if (!empty) begin
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			bpq_pkg::OP_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
				cnt_nxt = cnt_q;
			end
		endcase
	end

	assign ctl.add_en = in_acc && do_add;
	assign ctl.ext_en = in_acc && do_ext;

	// Row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     prev_ins;
		logic [TAG_BITS-1:0]      prev_tag;
		logic [PRIORITY_BITS-1:0] prev_pri;
		logic [TAG_BITS-1:0]      next_tag;
		logic [PRIORITY_BITS-1:0] next_pri;
		logic                     occupied;

		if (i == 0) begin : g_head
			assign prev_ins = 1'b0;
			assign prev_tag = entry_tag;
			assign prev_pri = priority_req;
		end else begin : g_body
			assign prev_ins = ins_w[i-1];
			assign prev_tag = tag_w[i-1];
			assign prev_pri = pri_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_tag = tag_w[i];
			assign next_pri = pri_w[i];
		end else begin : g_link
			assign next_tag = tag_w[i+1];
			assign next_pri = pri_w[i+1];
		end

		assign occupied = (CNT_W'(i) < cnt_q);

		bpq_cell #(
			.TAG_BITS      (TAG_BITS),
			.PRIORITY_BITS (PRIORITY_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occupied (occupied),
			.new_tag  (entry_tag),
			.new_pri  (priority_req),
			.prev_ins (prev_ins),
			.prev_tag (prev_tag),
			.prev_pri (prev_pri),
			.next_tag (next_tag),
			.next_pri (next_pri),
			.ins      (ins_w[i]),
			.tag      (tag_w[i]),
			.pri      (pri_w[i])
		);
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc) begin
			cnt_q <= cnt_nxt;
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (in_acc) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_tag_q   <= do_ext ? tag_w[0] : '0;
			out_valid_q <= do_ext;
			accepted_q  <= do_add;
			count_q     <= bpq_pkg::COUNT_W'(cnt_nxt);
			is_empty_q  <= (cnt_nxt == '0);
			is_full_q   <= (cnt_nxt == CNT_W'(DEPTH));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign out_tag   = out_tag_q;
	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign count     = count_q;
	assign is_empty  = is_empty_q;
	assign is_full   = is_full_q;

	// Checks
	`BPQ_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`BPQ_ASSERT_NOW(a_rsp_excl, clk, arst_n, rsp_valid_q, !(out_valid_q && accepted_q))
	`BPQ_ASSERT_NEXT(a_add_inc, clk, arst_n, ctl.add_en, cnt_q == $past(cnt_q) + CNT_W'(1))
	`BPQ_ASSERT_NOW(a_head_order, clk, arst_n, cnt_q >= CNT_W'(2), pri_w[0] >= pri_w[1])

endmodule
